### design/mmhq_pkg.sv
// Package: widths, status codes and shared types for the min-max heap queue.
package mmhq_pkg;
    localparam int unsigned Capacity = 1023;
    localparam int unsigned AddrW    = $clog2(Capacity + 1);
    localparam int unsigned CntW     = $clog2(Capacity + 1);
    localparam int unsigned KeyW     = 32;
    localparam int unsigned SizeW    = 10;

    localparam logic [1:0] StatusOk    = 2'd0;
    localparam logic [1:0] StatusFull  = 2'd1;
    localparam logic [1:0] StatusEmpty = 2'd2;

    localparam logic OpInsert = 1'b0;
    localparam logic OpDelMin = 1'b1;

    typedef logic [KeyW-1:0]  t_key;
    typedef logic [AddrW-1:0] t_addr;
    typedef logic [CntW-1:0]  t_cnt;

    // True when heap position p sits on a min level (even level, root = level 0).
    function automatic logic min_level(input t_addr p);
        logic lvl;
        lvl = 1'b0;
        for (int b = 0; b < AddrW; b++) begin
            if (p[b]) lvl = b[0];
        end
        return ~lvl;
    endfunction
endpackage

### design/mmhq_if.sv
// Valid/ready channel interfaces for requests and results.
interface mmhq_req_if;
    import mmhq_pkg::*;
    logic        valid;
    logic        ready;
    logic        op;
    logic signed [KeyW-1:0] key;
    modport source(output valid, op, key, input ready);
    modport sink(input valid, op, key, output ready);
endinterface

interface mmhq_rsp_if;
    import mmhq_pkg::*;
    logic        valid;
    logic        ready;
    logic signed [KeyW-1:0] removed_key;
    logic [1:0]             status;
    logic [SizeW-1:0]       size_after;
    logic signed [KeyW-1:0] min_now;
    logic signed [KeyW-1:0] max_now;
    modport source(output valid, removed_key, status, size_after, min_now, max_now,
                   input ready);
    modport sink(input valid, removed_key, status, size_after, min_now, max_now,
                 output ready);
endinterface

### design/min_max_heap_queue_core.sv
// Top level: min-max heap queue over a single-port synchronous key memory.
// Insert climbs the heap by grandparent hops until a compare stops the climb; delete-min sinks
//   the last key by grandchild steps from the root, capacity 1023 keys; insert when full or
//   delete when empty goes straight to the min/max read and the result.
// Throughput: one request at a time, the next taken once the result is accepted; the one memory
//   port sets it (one read or write per cycle). Reset: count and control clear, memory kept.
module min_max_heap_queue_core
    import mmhq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mmhq_req_if.sink    req,
    mmhq_rsp_if.source  rsp
);
    // Keys are stored with the sign bit flipped so unsigned compare is signed order.
    localparam logic [4:0] S_IDLE  = 5'd0,
                           S_INS_P = 5'd1,  // read parent
                           S_INS_C = 5'd2,  // compare with parent
                           S_UP_R  = 5'd3,  // read grandparent
                           S_UP_C  = 5'd4,  // compare with grandparent
                           S_DEL_L = 5'd5,  // read last entry
                           S_DEL_R = 5'd6,  // last entry arrives
                           S_TD_R  = 5'd7,  // issue descendant read
                           S_TD_C  = 5'd8,  // scan one descendant
                           S_TD_X  = 5'd9,  // decide swap
                           S_TD_W  = 5'd10, // unreached; moves on to S_TD_PR
                           S_TD_PR = 5'd11, // read parent of m
                           S_TD_PC = 5'd12, // compare with parent of m
                           S_FIN   = 5'd13, // write cur key at final spot
                           S_MM_R1 = 5'd14,
                           S_MM_R2 = 5'd15,
                           S_MM_R3 = 5'd16,
                           S_MM_D  = 5'd17,
                           S_OUT   = 5'd18;

    t_key  r_mem [Capacity+1];
    t_key  r_rd;
    t_addr mem_addr;
    logic  mem_we;
    t_key  mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wd;
        r_rd <= r_mem[mem_addr];
    end

    logic [4:0] r_st, n_st;
    t_cnt  r_cnt, n_cnt;
    t_addr r_i, n_i;          // hole position
    t_key  r_cur, n_cur;      // key being placed
    logic  r_tmin, n_tmin;    // bubble toward min chain
    t_addr r_m, n_m;          // best descendant
    t_key  r_mk, n_mk;
    logic [2:0] r_k, n_k;     // descendant scan index 0..5
    t_key  r_rem, n_rem;
    logic [1:0] r_stat, n_stat;
    t_key  r_mn, n_mn, r_mx, n_mx;
    logic  r_ov, n_ov;

    // Descendant address for scan index k: 2i, 2i+1, 4i..4i+3
    logic [AddrW+2:0] desc_w;
    always_comb begin
        if (r_k < 3'd2) desc_w = {2'b00, r_i, 1'b0} + (AddrW+3)'(r_k);
        else desc_w = {1'b0, r_i, 2'b00} + (AddrW+3)'(r_k - 3'd2);
    end
    logic desc_ok;
    assign desc_ok = desc_w <= (AddrW+3)'(r_cnt);

    assign req.ready = (r_st == S_IDLE) && !r_ov;
    assign rsp.valid = r_ov;
    assign rsp.removed_key = r_rem ^ 32'h8000_0000;
    assign rsp.status = r_stat;
    assign rsp.size_after = SizeW'(r_cnt);
    assign rsp.min_now = r_mn;
    assign rsp.max_now = r_mx;

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_i = r_i; n_cur = r_cur; n_tmin = r_tmin;
        n_m = r_m; n_mk = r_mk; n_k = r_k; n_rem = r_rem; n_stat = r_stat;
        n_mn = r_mn; n_mx = r_mx; n_ov = r_ov;
        mem_addr = r_i; mem_we = 1'b0; mem_wd = r_cur;
        if (r_ov && rsp.ready) n_ov = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (req.valid && req.ready) begin
                    n_rem = 32'h8000_0000;
                    n_stat = StatusOk;
                    if (req.op == OpInsert) begin
                        if (r_cnt >= t_cnt'(Capacity)) begin
                            n_stat = StatusFull;
                            n_st = S_MM_R1;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                            n_i = t_addr'(r_cnt + 1'b1);
                            n_cur = req.key ^ 32'h8000_0000;
                            n_st = (r_cnt == '0) ? S_FIN : S_INS_P;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_stat = StatusEmpty;
                            n_st = S_MM_R1;
                        end else begin
                            mem_addr = t_addr'(1);
                            n_st = S_DEL_L;
                        end
                    end
                end
            end
            S_INS_P: begin
                mem_addr = r_i >> 1;
                n_st = S_INS_C;
            end
            S_INS_C: begin
                if (min_level(r_i) ? (r_cur > r_rd) : (r_cur < r_rd)) begin
                    mem_addr = r_i; mem_we = 1'b1; mem_wd = r_rd;
                    n_i = r_i >> 1;
                    n_tmin = !min_level(r_i);
                end else begin
                    n_tmin = min_level(r_i);
                end
                n_st = S_UP_R;
            end
            S_UP_R: begin
                if (r_i >= t_addr'(4)) begin
                    mem_addr = r_i >> 2;
                    n_st = S_UP_C;
                end else n_st = S_FIN;
            end
            S_UP_C: begin
                if (r_tmin ? (r_cur < r_rd) : (r_cur > r_rd)) begin
                    mem_addr = r_i; mem_we = 1'b1; mem_wd = r_rd;
                    n_i = r_i >> 2;
                    n_st = S_UP_R;
                end else n_st = S_FIN;
            end
            S_DEL_L: begin
                n_rem = r_rd;
                mem_addr = t_addr'(r_cnt);
                n_cnt = r_cnt - 1'b1;
                n_st = S_DEL_R;
            end
            S_DEL_R: begin
                n_cur = r_rd;
                n_i = t_addr'(1);
                n_k = '0;
                n_st = (r_cnt == '0) ? S_MM_R1 : S_TD_R;
            end
            S_TD_R: begin
                if (r_k == 3'd0 && !desc_ok) n_st = S_FIN;
                else if (r_k == 3'd6 || !desc_ok) n_st = S_TD_X;
                else begin
                    mem_addr = desc_w[AddrW-1:0];
                    n_st = S_TD_C;
                end
            end
            S_TD_C: begin
                if (r_k == 3'd0 || r_rd < r_mk) begin
                    n_mk = r_rd;
                    n_m = desc_w[AddrW-1:0];
                end
                n_k = r_k + 1'b1;
                n_st = S_TD_R;
            end
            S_TD_X: begin
                n_k = '0;
                if (r_mk < r_cur) begin
                    mem_addr = r_i; mem_we = 1'b1; mem_wd = r_mk;
                    n_i = r_m;
                    // wide compare: 4i overflows the address width in the deep levels
                    n_st = ({2'b00, r_m} >= {r_i, 2'b00}) ? S_TD_PR : S_FIN;
                end else n_st = S_FIN;
            end
            S_TD_W: n_st = S_TD_PR;
            S_TD_PR: begin
                mem_addr = r_i >> 1;
                n_st = S_TD_PC;
            end
            S_TD_PC: begin
                if (r_cur > r_rd) begin
                    mem_addr = r_i >> 1; mem_we = 1'b1; mem_wd = r_cur;
                    n_cur = r_rd;
                end
                n_st = S_TD_R;
            end
            S_FIN: begin
                mem_addr = r_i; mem_we = 1'b1; mem_wd = r_cur;
                n_st = S_MM_R1;
            end
            S_MM_R1: begin
                mem_addr = t_addr'(1);
                n_st = S_MM_R2;
            end
            S_MM_R2: begin
                mem_addr = t_addr'(2);
                n_mn = r_rd; n_mx = r_rd;
                n_st = S_MM_R3;
            end
            S_MM_R3: begin
                mem_addr = t_addr'(3);
                if (r_cnt >= t_cnt'(2)) n_mx = r_rd;
                n_st = S_MM_D;
            end
            S_MM_D: begin
                if (r_cnt >= t_cnt'(3) && r_rd > r_mx) n_mx = r_rd;
                n_st = S_OUT;
            end
            S_OUT: begin
                if (r_cnt == '0) begin
                    n_mn = '0; n_mx = '0;
                end else begin
                    n_mn = r_mn ^ 32'h8000_0000;
                    n_mx = r_mx ^ 32'h8000_0000;
                end
                if (r_stat == StatusEmpty) n_rem = 32'h8000_0000;
                n_ov = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_ov <= n_ov;
        end
        r_i <= n_i; r_cur <= n_cur; r_tmin <= n_tmin; r_m <= n_m; r_mk <= n_mk;
        r_k <= n_k; r_rem <= n_rem; r_stat <= n_stat; r_mn <= n_mn; r_mx <= n_mx;
    end
endmodule

### design/mmhq_checker.sv
// Port-level checker for the min-max heap queue, bound to the top level.
module mmhq_checker
    import mmhq_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic [1:0] status,
    input logic [SizeW-1:0] size_after,
    input logic signed [KeyW-1:0] min_now,
    input logic signed [KeyW-1:0] max_now
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(size_after))
        else $error("result dropped while stalled");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && size_after != '0 |-> min_now <= max_now)
        else $error("min above max");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && status == StatusEmpty |-> size_after == '0)
        else $error("empty status with keys held");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while busy");
endmodule

bind min_max_heap_queue_core mmhq_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .status(rsp.status), .size_after(rsp.size_after),
    .min_now(rsp.min_now), .max_now(rsp.max_now)
);
